// File: rtl/ils_pkg.sv
// ils_pkg: shared types and constants for the indexed list store.
// Command and status codes, word type and the per-cell control bundle.
// No dependencies.
package ils_pkg;

    localparam int WORD_W  = 32;
    localparam int PIDX_W  = 9;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 8;
    localparam int CNTO_W  = 7;
    localparam int ST_W    = 2;
    localparam int SDATA_W = 48;
    localparam int MDATA_W = 48;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_INS_AT   = 3'd3,
        CMD_DELETE   = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [PIDX_W-1:0] pos;
        t_word             value;
    } t_cell_ctl;

endpackage

// File: rtl/ils_cell.sv
// ils_cell: one list slot of the store chain.
// Holds one word, shifts toward tail on insert and toward head on delete.
// Depends on ils_pkg.
module ils_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  ils_pkg::t_cell_ctl  i_ctl,
    input  ils_pkg::t_word      i_prev,
    input  ils_pkg::t_word      i_next,
    output ils_pkg::t_word      o_value,
    output ils_pkg::t_word      o_sel_value
);
    import ils_pkg::*;

    localparam logic [PIDX_W-1:0] MY_IDX = PIDX_W'(IDX);

    t_word r_value;
    t_word n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (MY_IDX == i_ctl.pos) begin
                n_value = i_ctl.value;
            end else if (MY_IDX > i_ctl.pos) begin
                n_value = i_prev;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_ctl.pos) begin
                n_value = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value     = r_value;
    // read tap: only the addressed cell drives the OR bus
    assign o_sel_value = (MY_IDX == i_ctl.pos) ? r_value : '0;

endmodule

// File: rtl/indexed_list_store.sv
// indexed_list_store: top level, command decode, count and output register.
// Instantiates a row of ils_cell slots; depends on ils_pkg.
//
// Usage:
//   Slave stream s_* carries one command per beat; master stream m_* returns
//   exactly one result beat per command, in order.
//   s_tdata (low bit up): cmd[2:0], position[10:3], value[42:11], zero pad.
//   m_tdata (low bit up): read_value[31:0], status[33:32], count[40:34], pad.
//   Each command is executed in the cycle it is accepted: every cell compares
//   its own slot number with the position and loads from its neighbor, the
//   new value or itself. The result is registered, and one command is taken
//   per cycle while the receiver keeps m_tready up.
//   When the result register holds an untaken beat, s_tready drops until it
//   is taken; the result then holds stable.
//   Reset (i_rst_n low, synchronous) empties the list, drops m_tvalid and
//   holds s_tready low; slot contents are not cleared and are only read
//   after being written.
//   Count is reported as its low 7 bits.
module indexed_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // cmd, position, value, pad
    input  logic [ils_pkg::SDATA_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // read_value, status, count, pad
    output logic [ils_pkg::MDATA_W-1:0] m_tdata
);
    import ils_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_word             r_read_value;
    t_word             n_read_value;
    t_status           r_status;
    t_status           n_status;

    logic              w_accept;
    t_cmd              w_cmd;
    logic [POS_W-1:0]  w_pos;
    t_word             w_value;
    logic [PIDX_W-1:0] w_pos_x;
    logic [PIDX_W-1:0] w_count_x;
    logic              w_full;
    t_cell_ctl         w_ctl;
    t_word             w_cell_val [CAPACITY];
    t_word             w_sel_val  [CAPACITY];
    t_word             w_rd_bus;

    assign w_cmd     = t_cmd'(s_tdata[CMD_W-1:0]);
    assign w_pos     = s_tdata[CMD_W +: POS_W];
    assign w_value   = s_tdata[CMD_W+POS_W +: WORD_W];
    assign w_pos_x   = PIDX_W'(w_pos);
    assign w_count_x = PIDX_W'(r_count);
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign s_tready  = i_rst_n && (!r_out_valid || m_tready);
    assign w_accept  = s_tvalid && s_tready;

    always_comb begin
        w_rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_bus = w_rd_bus | w_sel_val[i];
        end
    end

    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_status     = ST_DONE;
        w_ctl.ins    = 1'b0;
        w_ctl.del    = 1'b0;
        w_ctl.pos    = w_pos_x;
        w_ctl.value  = w_value;
        case (w_cmd)
            CMD_READ: begin
                if (w_pos_x < w_count_x) begin
                    n_read_value = w_rd_bus;
                end else begin
                    n_read_value = '1;
                    n_status     = ST_RANGE;
                end
            end
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                if (w_cmd == CMD_INS_HEAD) begin
                    w_ctl.pos = '0;
                end else if (w_cmd == CMD_INS_TAIL) begin
                    w_ctl.pos = w_count_x;
                end
                if (w_ctl.pos > w_count_x) begin
                    n_status = ST_RANGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                    n_count   = r_count + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (w_pos_x < w_count_x) begin
                    w_ctl.del = w_accept;
                    n_count   = r_count - 1'b1;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_word w_prev;
            t_word w_next;
            if (g == 0) begin : g_head
                assign w_prev = '0;
            end else begin : g_mid_p
                assign w_prev = w_cell_val[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_mid_n
                assign w_next = w_cell_val[g+1];
            end
            ils_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_prev      (w_prev),
                .i_next      (w_next),
                .o_value     (w_cell_val[g]),
                .o_sel_value (w_sel_val[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(MDATA_W - WORD_W - ST_W - CNTO_W){1'b0}},
                       CNTO_W'(r_count), r_status, r_read_value};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) ||
                  r_count == $past(r_count) + 1'b1 ||
                  r_count + 1'b1 == $past(r_count)))
        else $error("entry count moved by more than one");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> w_full)
        else $error("full status with list not full");

    a_bad_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_DONE && r_read_value != '0)
        |-> r_read_value == '1)
        else $error("failed command returned a stray value");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

// File: tb/sv/tb_indexed_list_store.sv
// tb_indexed_list_store: self-checking stream testbench for indexed_list_store.
// Directed table plus phased random commands, checked against table replies or a shadow list.
// Depends on ils_pkg and the indexed_list_store RTL.
`timescale 1ns / 100ps

module tb_indexed_list_store;
    import ils_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD = 200;
    localparam int PHASE_LEN = 50;
    localparam int NUM_PHASES = 12;
    localparam int NUM_ROWS = 25;
    localparam int PH_FILL = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_CHURN = 2;
    localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct {
        t_word             rd;
        t_status           st;
        logic [CNTO_W-1:0] cnt;
    } list_reply_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        t_word             val;
        bit                typed;
        t_word             rd;
        t_status           st;
        logic [CNTO_W-1:0] cnt;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [SDATA_W-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MDATA_W-1:0]   m_tdata;

    t_word       shadow_words [LIST_DEPTH];
    int          shadow_count = 0;
    list_reply_t pending_replies [$];
    int          mismatches = 0;
    int          replies_seen = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          stall_cycles = 0;
    int          n_done = 0;
    int          n_range = 0;
    int          n_full = 0;
    int          peak_count = 0;
    bit          hold_done = 1'b0;

    // cmd, pos, val, typed, rd, st, cnt
    stim_row_t dir_rows [NUM_ROWS] = '{
        '{CMD_READ,     8'd0,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_RANGE, 7'd0},
        '{CMD_DELETE,   8'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
        '{CMD_INS_AT,   8'd1,   32'h1234_5678, 1'b1, 32'h0000_0000, ST_RANGE, 7'd0},
        '{CMD_INS_HEAD, 8'd0,   32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE,  7'd1},
        '{CMD_INS_TAIL, 8'd0,   32'h8000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd2},
        '{CMD_INS_AT,   8'd1,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE,  7'd3},
        '{CMD_INS_AT,   8'd3,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd4},
        '{CMD_INS_AT,   8'd5,   32'h5555_5555, 1'b1, 32'h0000_0000, ST_RANGE, 7'd4},
        '{CMD_READ,     8'd0,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
        '{CMD_READ,     8'd1,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
        '{CMD_READ,     8'd2,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
        '{CMD_READ,     8'd3,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
        '{CMD_READ,     8'd4,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_RANGE, 7'd4},
        '{CMD_READ,     8'd255, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_RANGE, 7'd4},
        '{CMD_SPARE5,   8'd0,   32'h1111_1111, 1'b1, 32'h0000_0000, ST_RANGE, 7'd4},
        '{CMD_SPARE6,   8'd1,   32'h2222_2222, 1'b1, 32'h0000_0000, ST_RANGE, 7'd4},
        '{CMD_SPARE7,   8'd255, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_RANGE, 7'd4},
        '{CMD_DELETE,   8'd4,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd4},
        '{CMD_DELETE,   8'd255, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_RANGE, 7'd4},
        '{CMD_INS_AT,   8'd255, 32'h5555_5555, 1'b1, 32'h0000_0000, ST_RANGE, 7'd4},
        '{CMD_DELETE,   8'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd3},
        '{CMD_DELETE,   8'd2,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE,  7'd2},
        '{CMD_READ,     8'd0,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
        '{CMD_READ,     8'd1,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE,  7'd0},
        '{CMD_INS_HEAD, 8'd170, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, ST_DONE,  7'd3}
    };

    int phase_kind [NUM_PHASES] = '{
        PH_FILL, PH_FILL, PH_FILL, PH_CHURN, PH_DRAIN, PH_DRAIN,
        PH_DRAIN, PH_CHURN, PH_FILL, PH_FILL, PH_FILL, PH_CHURN
    };

    indexed_list_store #(
        .CAPACITY(LIST_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_status list_insert(input int at, input t_word v);
        if (at > shadow_count) begin
            return ST_RANGE;
        end
        if (shadow_count >= LIST_DEPTH) begin
            return ST_FULL;
        end
        for (int i = shadow_count; i > at; i--) begin
            shadow_words[i] = shadow_words[i-1];
        end
        shadow_words[at] = v;
        shadow_count++;
        return ST_DONE;
    endfunction

    function automatic list_reply_t list_apply(input logic [CMD_W-1:0] c,
                                               input logic [POS_W-1:0] p,
                                               input t_word v);
        list_reply_t r;
        int          at;
        r.rd = '0;
        r.st = ST_DONE;
        at = int'(p);
        case (c)
            CMD_READ: begin
                if (at < shadow_count) begin
                    r.rd = shadow_words[at];
                end else begin
                    r.rd = -32'sd1;
                    r.st = ST_RANGE;
                end
            end
            CMD_INS_HEAD: r.st = list_insert(0, v);
            CMD_INS_TAIL: r.st = list_insert(shadow_count, v);
            CMD_INS_AT:   r.st = list_insert(at, v);
            CMD_DELETE: begin
                if (at < shadow_count) begin
                    for (int i = at; i + 1 < shadow_count; i++) begin
                        shadow_words[i] = shadow_words[i+1];
                    end
                    shadow_count--;
                end else begin
                    r.st = ST_RANGE;
                end
            end
            default: r.st = ST_RANGE;
        endcase
        r.cnt = shadow_count[CNTO_W-1:0];
        return r;
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input t_word v, input bit typed, input list_reply_t want);
        list_reply_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SDATA_W-WORD_W-POS_W-CMD_W){1'b0}}, v, p, c};
        do @(posedge i_clk); while (!s_tready);
        r = list_apply(c, p, v);
        pending_replies.push_back(typed ? want : r);
        if (shadow_count > peak_count) begin
            peak_count = shadow_count;
        end
        items_sent++;
        burst_left--;
    endtask

    task automatic pace_sender();
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic pick_command(input int kind, output logic [CMD_W-1:0] c,
                                output logic [POS_W-1:0] p, output t_word v);
        int roll;
        int rd_top;
        int ins_top;
        roll = $urandom_range(0, 99);
        rd_top = (kind == PH_FILL) ? 13 : (kind == PH_DRAIN) ? 18 : 38;
        ins_top = (kind == PH_FILL) ? 88 : (kind == PH_DRAIN) ? 41 : 69;
        if (roll < 3) begin
            c = CMD_SPARE5 + 3'($urandom_range(0, 2));
        end else if (roll < rd_top) begin
            c = CMD_READ;
        end else if (roll < ins_top) begin
            case ($urandom_range(0, 2))
                0:       c = CMD_INS_HEAD;
                1:       c = CMD_INS_TAIL;
                default: c = CMD_INS_AT;
            endcase
        end else begin
            c = CMD_DELETE;
        end
        roll = $urandom_range(0, 99);
        if (roll >= 85) begin
            p = 8'($urandom_range(0, 255));
        end else if (c == CMD_INS_AT) begin
            p = 8'($urandom_range(0, shadow_count));
        end else if (shadow_count > 0 && (c == CMD_READ || c == CMD_DELETE)) begin
            p = 8'($urandom_range(0, shadow_count - 1));
        end else begin
            p = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h0000_0000;
            default: v = t_word'($urandom);
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        list_reply_t want;
        list_reply_t got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.rd  = t_word'(m_tdata[31:0]);
            got.st  = t_status'(m_tdata[33:32]);
            got.cnt = m_tdata[40:34];
            replies_seen++;
            case (got.st)
                ST_DONE:  n_done++;
                ST_RANGE: n_range++;
                ST_FULL:  n_full++;
                default:  ;
            endcase
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected beat %0d: rd=%h st=%0d cnt=%0d",
                             replies_seen, got.rd, got.st, got.cnt);
                end
            end else begin
                want = pending_replies.pop_front();
                if (got.rd !== want.rd || got.st !== want.st || got.cnt !== want.cnt) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("beat %0d mismatch: exp rd=%h st=%0d cnt=%0d, got rd=%h st=%0d cnt=%0d",
                                 replies_seen, want.rd, want.st, want.cnt,
                                 got.rd, got.st, got.cnt);
                    end
                end
            end
        end
    end

    // receiver: shifting ready patterns plus one long hold-off
    initial begin
        int rx_mode;
        int rx_left;
        rx_mode = 0;
        rx_left = 0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && replies_seen >= 150) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (rx_left <= 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(8, 60);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;
        t_word            v;
        list_reply_t      want;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < NUM_ROWS; i++) begin
            pace_sender();
            want.rd  = dir_rows[i].rd;
            want.st  = dir_rows[i].st;
            want.cnt = dir_rows[i].cnt;
            send_beat(dir_rows[i].cmd, dir_rows[i].pos, dir_rows[i].val,
                      dir_rows[i].typed, want);
        end
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // drain everything in flight before the next phase
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while (pending_replies.size() != 0);
            for (int k = 0; k < PHASE_LEN; k++) begin
                pace_sender();
                pick_command(phase_kind[ph], c, p, v);
                send_beat(c, p, v, 1'b0, want);
            end
        end
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
        repeat (4) @(posedge i_clk);
        $display("%0d commands (%0d from table): %0d done, %0d out of range, %0d full",
                 items_sent, NUM_ROWS, n_done, n_range, n_full);
        $display("peak fill %0d of %0d, %0d mismatches, long output stall %0s",
                 peak_count, LIST_DEPTH, mismatches, hold_done ? "seen" : "missed");
        if (mismatches == 0 && pending_replies.size() == 0 && !m_tvalid) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
